[src/suh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suh_pkg: shared types for the seek undo/redo history
// Command and result beat layouts, mode codes and the stored entry layout.
// ----------------------------------------------------------------------------
package suh_pkg;

	localparam int OFS_W   = 64;
	localparam int COL_W   = 16;
	localparam int CNT_W   = 6;
	localparam int ENTRY_W = OFS_W + COL_W;

	// Command codes
	typedef enum logic [1:0] {
		MODE_PUSH  = 2'd0,
		MODE_UNDO  = 2'd1,
		MODE_REDO  = 2'd2,
		MODE_RESET = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t             mode;
		logic [OFS_W-1:0]  position;
		logic [COL_W-1:0]  column;
	} cmd_t;

	typedef struct packed {
		logic              hit;
		logic [OFS_W-1:0]  entry_offset;
		logic [COL_W-1:0]  entry_column;
		logic [CNT_W-1:0]  undo_count;
		logic [CNT_W-1:0]  redo_count;
	} result_t;

	// One saved position in the history ring
	typedef struct packed {
		logic [OFS_W-1:0]  offset;
		logic [COL_W-1:0]  column;
	} entry_t;

endpackage

[src/suh_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suh_ram: history ring storage
// Simple dual-port memory, one write and one read per cycle, registered read.
// ----------------------------------------------------------------------------
module suh_ram #(
	parameter int DEPTH = 64
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [$clog2(DEPTH)-1:0]  waddr,
	input  suh_pkg::entry_t           wdata,
	input  logic [$clog2(DEPTH)-1:0]  raddr,
	output suh_pkg::entry_t           rdata
);

	suh_pkg::entry_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[src/seek_undo_redo_history.sv]
`timescale 1ns / 1ps
// A command is registered into cmd_s1 when accepted; S_EXEC then registers its result beat.
// No new command is taken while busy in S_EXEC, which leaves room for the ring memory's
//   registered read ahead of the read-modify-write step.
// Reset clears ring index, both counts and the enable; stored entries are kept.
// The result beat is held for one cycle only; the receiver cannot stall it.
// ----------------------------------------------------------------------------
// seek_undo_redo_history: linear undo/redo history of seek positions
// Ring of DEPTH (offset, column) entries with push, undo, redo and reset.
// ----------------------------------------------------------------------------
module seek_undo_redo_history #(
	parameter int DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	// command channel
	input  logic              start,
	output logic              busy,
	input  suh_pkg::cmd_t     command,
	// result channel
	output logic              done,
	output suh_pkg::result_t  result,
	// configuration channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data
);

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t            state_q;
	logic              busy_q;
	logic              done_q;
	logic              en_q;
	logic [AW-1:0]     idx_q;
	logic [AW-1:0]     undo_q;
	logic [AW-1:0]     redo_q;
	suh_pkg::cmd_t     cmd_s1;
	suh_pkg::result_t  result_q;

	logic              accept;
	logic              dup;
	logic              wr_undo;
	logic              wr_push;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [AW-1:0]     ram_raddr;
	suh_pkg::entry_t   ram_wdata;
	suh_pkg::entry_t   rd_entry;

	logic [AW-1:0]     idx_d;
	logic [AW-1:0]     undo_d;
	logic [AW-1:0]     redo_d;
	logic              hit_d;
	suh_pkg::entry_t   ent_d;

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
		return (i == LAST_IDX) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
		return (i == '0) ? LAST_IDX : i - 1'b1;
	endfunction

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = busy_q;
	assign done      = done_q;
	assign result    = result_q;
	assign cfg_ready = 1'b1;

	// undo saves the current offset before stepping back, only with no redos
	assign wr_undo = accept && (command.mode == suh_pkg::MODE_UNDO) && en_q
		&& (undo_q != '0) && (redo_q == '0);

	// dup check against the newest saved entry, read at accept
	assign dup = (undo_q != '0) && (rd_entry.offset == cmd_s1.position)
		&& (rd_entry.column == cmd_s1.column);

	assign wr_push = (state_q == S_EXEC) && (cmd_s1.mode == suh_pkg::MODE_PUSH)
		&& en_q && !dup;

	// memory port muxing; the two writes never fall in the same cycle
	always_comb begin
		ram_we    = wr_undo || wr_push;
		ram_waddr = idx_q;
		if (wr_undo) begin
			ram_wdata.offset = command.position;
			ram_wdata.column = '0;
		end else begin
			ram_wdata.offset = cmd_s1.position;
			ram_wdata.column = cmd_s1.column;
		end
		if (command.mode == suh_pkg::MODE_REDO) begin
			ram_raddr = ring_next(idx_q);
		end else begin
			ram_raddr = ring_prev(idx_q);
		end
	end

	suh_ram #(
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rd_entry)
	);

	// execute step: new counters and returned entry
	always_comb begin
		idx_d  = idx_q;
		undo_d = undo_q;
		redo_d = redo_q;
		hit_d  = 1'b0;
		ent_d  = '0;
		case (cmd_s1.mode)
			suh_pkg::MODE_RESET: begin
				idx_d  = '0;
				undo_d = '0;
				redo_d = '0;
			end
			suh_pkg::MODE_PUSH: begin
				if (en_q && !dup) begin
					idx_d  = ring_next(idx_q);
					undo_d = (undo_q == LAST_IDX) ? undo_q : undo_q + 1'b1;
					redo_d = '0;
				end
			end
			suh_pkg::MODE_UNDO: begin
				if (en_q && (undo_q != '0)) begin
					idx_d  = ring_prev(idx_q);
					undo_d = undo_q - 1'b1;
					redo_d = redo_q + 1'b1;
					hit_d  = 1'b1;
					ent_d  = rd_entry;
				end
			end
			suh_pkg::MODE_REDO: begin
				if (en_q && (redo_q != '0)) begin
					idx_d  = ring_next(idx_q);
					undo_d = undo_q + 1'b1;
					redo_d = redo_q - 1'b1;
					hit_d  = 1'b1;
					ent_d  = rd_entry;
				end
			end
			default: ;
		endcase
	end

	// control FSM, counters and enable register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			en_q    <= 1'b0;
			idx_q   <= '0;
			undo_q  <= '0;
			redo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid) begin
				en_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
						busy_q  <= 1'b1;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
					idx_q   <= idx_d;
					undo_q  <= undo_d;
					redo_q  <= redo_d;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= command;
		end
		if (state_q == S_EXEC) begin
			result_q.hit          <= hit_d;
			result_q.entry_offset <= ent_d.offset;
			result_q.entry_column <= ent_d.column;
			result_q.undo_count   <= suh_pkg::CNT_W'(undo_d);
			result_q.redo_count   <= suh_pkg::CNT_W'(redo_d);
		end
	end

endmodule

[src/suh_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suh_checker: port-level checks for the seek history
// Watches command acceptance and result beats on the top level.
// ----------------------------------------------------------------------------
module suh_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic              done,
	input  suh_pkg::result_t  result
);

	// an accepted command blocks further commands for the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after command accept");

	// a result beat follows every accepted command
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("result beat missing two cycles after accept");

	// no result beat without a matching accepted command
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result beat without a matching command");

	// strobe lasts one cycle per command
	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	// a miss returns an empty entry
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.hit) |-> (result.entry_offset == '0 && result.entry_column == '0))
		else $error("entry fields not zero on a miss");

endmodule

bind seek_undo_redo_history suh_checker u_suh_checker (.*);
